>>> hdl/frhc_pkg.sv
// Package for the frame header and CRC-16/Modbus checker.
// Holds the shared constants, transaction and result types, and the CRC byte update.
// No dependencies.
`timescale 1ns / 1ps

package frhc_pkg;

    // CRC-16/Modbus: reflected polynomial, all-ones start value.
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    // Expected ASCII header bytes.
    localparam logic [7:0]  HDR_CHAR0 = 8'h4E;  // 'N'
    localparam logic [7:0]  HDR_CHAR1 = 8'h4F;  // 'O'
    localparam logic [7:0]  HDR_CHAR2 = 8'h57;  // 'W'

    // Byte counter width and its saturation value.
    localparam int          CNT_W     = 3;
    localparam logic [CNT_W-1:0] CNT_MAX   = 3'd7;
    // Header length, delay line depth and the fewest bytes a valid frame can have.
    localparam logic [CNT_W-1:0] HDR_LEN   = 3'd3;
    localparam logic [CNT_W-1:0] DLY_LEN   = 3'd2;
    localparam logic [CNT_W-1:0] MIN_FRAME = 3'd5;

    // Frame verdict codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_HDR = 2'd2,
        ST_BAD_CRC = 2'd3
    } t_status;

    // One input transaction.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_last;
        logic       status_valid;
        t_status    frame_status;
    } t_result;

    // Bytewise reflected CRC update, one bit of the byte per step.
    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Header byte expected at a given position (0..2).
    function automatic logic [7:0] header_char(logic [CNT_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = HDR_CHAR0;
            3'd1:    ch = HDR_CHAR1;
            default: ch = HDR_CHAR2;
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/frame_header_crc_checker_unit.sv
// Top level of the frame header and CRC-16/Modbus checker.
// Instantiates frhc_in_reg and frhc_check and holds the result register.
// Depends on frhc_pkg.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------------
//  rx      | in        | i_rx_valid / o_rx_stall  | i_rx_byte, i_frame_end
//  res     | out       | o_res_valid / i_res_stall| o_out_valid, o_out_byte, o_out_last,
//          |           |                          | o_status_valid, o_frame_status
//
// Each transaction yields exactly one result transaction, via the input and result registers.
// One transaction is accepted per cycle while the result channel is not stalled; the rate is
// set by the combinational CRC byte update between the input register and the result register.
// Reset is synchronous and active low; it clears the frame state and both valid flags.
// A stalled result holds; the input register keeps accepting until it too is full.
`timescale 1ns / 1ps

module frame_header_crc_checker_unit
    import frhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_status_valid,
    output logic [1:0] o_frame_status
);

    t_item   w_in_item;
    t_item   w_s1_item;
    logic    w_s1_valid;
    logic    w_advance;
    t_result w_result;

    logic    r_out_valid;
    t_result r_out;

    assign w_in_item.rx_byte   = i_rx_byte;
    assign w_in_item.frame_end = i_frame_end;

    // A held transaction moves on when the result register is free or draining.
    assign w_advance = w_s1_valid && (!r_out_valid || !i_res_stall);

    // Input register.
    frhc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .i_item  (w_in_item),
        .o_stall (o_rx_stall),
        .i_take  (w_advance),
        .o_valid (w_s1_valid),
        .o_item  (w_s1_item)
    );

    // Check logic and frame state.
    frhc_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (w_s1_item),
        .o_result (w_result)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded only when a transaction moves in.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_out_valid    = r_out.out_valid;
    assign o_out_byte     = r_out.out_byte;
    assign o_out_last     = r_out.out_last;
    assign o_status_valid = r_out.status_valid;
    assign o_frame_status = r_out.frame_status;

endmodule

>>> hdl/frhc_in_reg.sv
// Input register stage of the frame checker.
// Captures one transaction and holds it until the check stage consumes it.
// Depends on frhc_pkg.
`timescale 1ns / 1ps

module frhc_in_reg
    import frhc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_stall,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // The stage can load when empty or when its content leaves this cycle.
    assign w_load  = !r_valid || i_take;
    assign o_stall = !w_load;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    // Payload holds while the stage is occupied.
    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> hdl/frhc_check.sv
// Frame check stage: header compare, CRC accumulation, two-byte delay and verdict.
// Holds the per-frame state and produces one result per consumed transaction.
// Depends on frhc_pkg.
`timescale 1ns / 1ps

module frhc_check
    import frhc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic [15:0]      r_crc,  n_crc;
    logic [7:0]       r_hold0, n_hold0;
    logic [7:0]       r_hold1, n_hold1;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_hdr_good, n_hdr_good;

    logic [15:0]      w_crc;
    logic [15:0]      w_rx_crc;
    logic             w_hdr_good;
    logic             w_emit;

    // Header check, delayed byte and CRC over the byte leaving the delay line.
    always_comb begin
        w_hdr_good = r_hdr_good;
        if (r_count < HDR_LEN && i_item.rx_byte != header_char(r_count)) begin
            w_hdr_good = 1'b0;
        end
        w_emit   = (r_count >= DLY_LEN);
        w_crc    = w_emit ? crc16_update(r_crc, r_hold1) : r_crc;
        w_rx_crc = {i_item.rx_byte, r_hold0};
    end

    // Result of this transaction; the verdict is given on the last byte.
    always_comb begin
        o_result.out_valid    = w_emit;
        o_result.out_byte     = w_emit ? r_hold1 : 8'h00;
        o_result.out_last     = i_item.frame_end;
        o_result.status_valid = i_item.frame_end;
        o_result.frame_status = ST_OK;
        if (i_item.frame_end) begin
            if (r_count < MIN_FRAME - 3'd1) begin
                o_result.frame_status = ST_SHORT;
            end else if (!w_hdr_good) begin
                o_result.frame_status = ST_BAD_HDR;
            end else if (w_rx_crc != w_crc) begin
                o_result.frame_status = ST_BAD_CRC;
            end
        end
    end

    // Next state: advance within a frame, return to the start after its last byte.
    always_comb begin
        n_crc      = r_crc;
        n_hold0    = r_hold0;
        n_hold1    = r_hold1;
        n_count    = r_count;
        n_hdr_good = r_hdr_good;
        if (i_fire) begin
            if (i_item.frame_end) begin
                n_crc      = CRC_INIT;
                n_hold0    = 8'h00;
                n_hold1    = 8'h00;
                n_count    = '0;
                n_hdr_good = 1'b1;
            end else begin
                n_crc      = w_crc;
                n_hold1    = r_hold0;
                n_hold0    = i_item.rx_byte;
                n_hdr_good = w_hdr_good;
                if (r_count < CNT_MAX) begin
                    n_count = r_count + 3'd1;
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_INIT;
            r_hold0    <= 8'h00;
            r_hold1    <= 8'h00;
            r_count    <= '0;
            r_hdr_good <= 1'b1;
        end else begin
            r_crc      <= n_crc;
            r_hold0    <= n_hold0;
            r_hold1    <= n_hold1;
            r_count    <= n_count;
            r_hdr_good <= n_hdr_good;
        end
    end

    // A frame's last byte returns the frame state to its start values.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.frame_end |=>
            r_count == '0 && r_crc == CRC_INIT && r_hdr_good)
        else $error("frame state not restarted after last byte");

    // Inside a frame the byte count steps by one until it saturates.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_item.frame_end && r_count != CNT_MAX |=>
            r_count == $past(r_count) + 3'd1)
        else $error("byte count did not advance");

    // The delay line shifts by one position on every non-final byte.
    a_delay_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_item.frame_end |=>
            r_hold1 == $past(r_hold0) && r_hold0 == $past(i_item.rx_byte))
        else $error("delay line did not shift");

    // Once a header mismatch is seen it stays until the frame ends.
    a_hdr_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hdr_good && !(i_fire && i_item.frame_end) |=> !r_hdr_good)
        else $error("header mismatch flag cleared within a frame");

endmodule

>>> bench/frhc_result_checker.sv
// Result checker for the frame header and CRC-16/Modbus checker bench.
// Watches both channels, predicts each result from the accepted bytes and compares.
// Depends on frhc_pkg for the result type, the verdict codes and the constants.
`timescale 1ns / 1ps

module frhc_result_checker
    import frhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic       i_rx_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic       i_out_valid,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    input  logic       i_status_valid,
    input  logic [1:0] i_frame_status,
    output int         o_fail_count,
    output int         o_pending
);

    // Frame state of the predictor.
    logic [15:0]     crc_sum;
    logic [7:0]      lag1;
    logic [7:0]      lag2;
    logic [CNT_W-1:0] seen_count;
    logic            hdr_match;

    // Results still owed by the block, oldest first.
    t_result         expected_results[$];
    t_result         want;
    int              fail_count = 0;

    // Reflected CRC-16, folding one data bit per step.
    function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] data);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb  = crc[0] ^ data[k];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic [7:0] expected_header(logic [CNT_W-1:0] pos);
        case (pos)
            3'd0:    return HDR_CHAR0;
            3'd1:    return HDR_CHAR1;
            default: return HDR_CHAR2;
        endcase
    endfunction

    function void clear_frame();
        crc_sum    = CRC_INIT;
        lag1       = 8'h00;
        lag2       = 8'h00;
        seen_count = '0;
        hdr_match  = 1'b1;
    endfunction

    // Works out the result of one accepted byte and queues it.
    function void predict_byte_result(logic [7:0] b, logic last);
        t_result     r;
        logic [15:0] crc_next;
        logic [15:0] rx_crc;
        r        = '0;
        crc_next = crc_sum;
        if (seen_count < HDR_LEN && b != expected_header(seen_count)) begin
            hdr_match = 1'b0;
        end
        // The byte leaving the two-deep delay line passes out and enters the CRC.
        if (seen_count >= DLY_LEN) begin
            r.out_valid = 1'b1;
            r.out_byte  = lag2;
            crc_next    = crc_fold(crc_next, lag2);
        end
        r.out_last     = last;
        r.status_valid = last;
        if (last) begin
            // The received CRC comes low byte first.
            rx_crc = {b, lag1};
            if (int'(seen_count) + 1 < int'(MIN_FRAME)) begin
                r.frame_status = ST_SHORT;
            end else if (!hdr_match) begin
                r.frame_status = ST_BAD_HDR;
            end else if (rx_crc != crc_next) begin
                r.frame_status = ST_BAD_CRC;
            end else begin
                r.frame_status = ST_OK;
            end
            clear_frame();
        end else begin
            crc_sum = crc_next;
            lag2    = lag1;
            lag1    = b;
            if (seen_count != CNT_MAX) begin
                seen_count = seen_count + 1'b1;
            end
        end
        expected_results.push_back(r);
    endfunction

    // Predict on every input transaction, compare on every result transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            expected_results.delete();
        end else begin
            if (i_rx_valid && !i_rx_stall) begin
                predict_byte_result(i_rx_byte, i_frame_end);
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_valid !== want.out_valid) begin
                        $error("out_valid: expected %0d, got %0d", want.out_valid, i_out_valid);
                        fail_count++;
                    end
                    if (i_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, i_out_byte);
                        fail_count++;
                    end
                    if (i_out_last !== want.out_last) begin
                        $error("out_last: expected %0d, got %0d", want.out_last, i_out_last);
                        fail_count++;
                    end
                    if (i_status_valid !== want.status_valid) begin
                        $error("status_valid: expected %0d, got %0d",
                               want.status_valid, i_status_valid);
                        fail_count++;
                    end
                    if (i_frame_status !== want.frame_status) begin
                        $error("frame_status: expected %0d, got %0d",
                               want.frame_status, i_frame_status);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = expected_results.size();
    end

endmodule

>>> bench/tb_top.sv
// Top of the frame header and CRC-16/Modbus checker bench.
// Drives framed bytes with random idling and stalls; frhc_result_checker does the checking.
// Depends on frhc_pkg, frame_header_crc_checker_unit and frhc_result_checker.
`timescale 1ns / 1ps

module tb_top;
    import frhc_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_ITEMS = 950;
    localparam logic [23:0] HDR_WORD     = {HDR_CHAR0, HDR_CHAR1, HDR_CHAR2};

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_frame_end = 1'b0;
    logic       i_res_stall = 1'b0;
    logic       o_rx_stall;
    logic       o_res_valid;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_status_valid;
    logic [1:0] o_frame_status;
    int         fail_count;
    int         pending;

    int         items_sent  = 0;
    int         cycle_count = 0;
    int         send_burst  = 0;
    logic [7:0] frame_buf[$];

    frame_header_crc_checker_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_end    (i_frame_end),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_out_last     (o_out_last),
        .o_status_valid (o_status_valid),
        .o_frame_status (o_frame_status)
    );

    frhc_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .i_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_end    (i_frame_end),
        .i_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .i_out_valid    (o_out_valid),
        .i_out_byte     (o_out_byte),
        .i_out_last     (o_out_last),
        .i_status_valid (o_status_valid),
        .i_frame_status (o_frame_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Receiver stalls: random runs, plus one long hold-off once traffic is flowing.
    initial begin
        int  free_left;
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        free_left  = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_res_stall <= 1'b1;
                hold_left--;
            end else if (!hold_done && items_sent >= 300) begin
                hold_done   = 1'b1;
                hold_left   = 149;
                i_res_stall <= 1'b1;
            end else if (stall_left > 0) begin
                i_res_stall <= 1'b1;
                stall_left--;
            end else if (free_left > 0) begin
                i_res_stall <= 1'b0;
                free_left--;
            end else begin
                free_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                          : $urandom_range(0, 12);
                stall_left  = pick_idle();
                i_res_stall <= 1'b0;
            end
        end
    end

    // Offers one byte after a random gap, none within a burst, and waits for its transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 49) == 0) begin
                send_burst = $urandom_range(20, 60);
            end
            gap = pick_idle();
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_frame_end <= last;
        do @(posedge i_clk); while (o_rx_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic play_frame();
        foreach (frame_buf[i]) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // Withdraws the offer, then waits until every owed result has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [15:0] modbus_crc();
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (frame_buf[i]) begin
            crc = crc ^ {8'h00, frame_buf[i]};
            repeat (8) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    // Builds a frame: header, random payload, then the CRC low byte first.
    // Frames under five bytes carry no CRC; a broken header is one corrupted byte, a broken CRC a nonzero XOR.
    task automatic build_frame(input int len, input bit hdr_ok, input bit crc_ok);
        int          body;
        int          bad_pos;
        logic [15:0] crc;
        frame_buf.delete();
        body = (len >= 5) ? len - 2 : len;
        for (int i = 0; i < body; i++) begin
            frame_buf.push_back(i < 3 ? HDR_WORD[23 - 8 * i -: 8] : 8'($urandom));
        end
        if (!hdr_ok) begin
            bad_pos = $urandom_range(0, (body < 3) ? body - 1 : 2);
            frame_buf[bad_pos] = frame_buf[bad_pos] ^ 8'($urandom_range(1, 255));
        end
        if (len >= 5) begin
            crc = modbus_crc();
            if (!crc_ok) begin
                crc = crc ^ 16'($urandom_range(1, 65535));
            end
            frame_buf.push_back(crc[7:0]);
            frame_buf.push_back(crc[15:8]);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int len;
        int r;
        int target;
        bit paused;
        paused = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: shortest frames, extreme bytes, each verdict and their precedence.
        frame_buf = '{8'h00};
        play_frame();
        frame_buf = '{HDR_CHAR0, HDR_CHAR1, HDR_CHAR2, 8'hFF};
        play_frame();
        build_frame(5, 1'b1, 1'b1);
        play_frame();
        build_frame(5, 1'b0, 1'b1);
        play_frame();
        build_frame(5, 1'b1, 1'b0);
        play_frame();
        build_frame(5, 1'b0, 1'b0);
        play_frame();

        // Random frames, mostly well formed, with short and broken ones mixed in.
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                len = $urandom_range(1, 4);
            end else if (r < 90) begin
                len = $urandom_range(5, 10);
            end else begin
                len = $urandom_range(11, 24);
            end
            build_frame(len, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 80);
            play_frame();
            // Now and then, and past 600 items if it has not paused yet, the sender waits for the block to drain.
            if ((!paused && items_sent >= 600) || $urandom_range(0, 39) == 0) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
